/* hw/rtl/drs_pkg.sv */
// ----------------------------------------------------------------------------
// Disk request scheduler package
// Shared widths, register indexes, request and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W        = $clog2(MAX_REQUESTS);
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int TRACK_W      = 16;
	localparam int DIST_W       = TRACK_W + 1;
	localparam int SEEK_W       = 22;
	localparam int CFG_W        = 17;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_SIZE   = 2'd2;

	localparam logic [1:0] ALG_SSTF  = 2'd0;
	localparam logic [1:0] ALG_SCAN  = 2'd1;
	localparam logic [1:0] ALG_CLOOK = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [TRACK_W-1:0] track;
	} req_t;

	typedef struct packed {
		logic [TRACK_W-1:0] service_track;
		logic [SEEK_W-1:0]  total_seek;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic               clear;
		logic               vld;
		logic               skip;
		logic               use_dist;
		logic               want_max;
		logic [IDX_W-1:0]   idx;
		logic [TRACK_W-1:0] lo;
		logic [TRACK_W-1:0] hi;
	} unit_ctl_t;

	typedef struct packed {
		logic               found;
		logic [IDX_W-1:0]   idx;
		logic [TRACK_W-1:0] track;
	} unit_res_t;

endpackage

`default_nettype wire

/* hw/rtl/drs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/drs_unit.sv */
// ----------------------------------------------------------------------------
// Disk request scheduler compare unit
// Shared distance and compare datapath that tracks the best candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_unit import drs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire unit_ctl_t          ctl,
	input  wire logic [TRACK_W-1:0] opa,
	input  wire logic [TRACK_W-1:0] head,
	output logic [DIST_W-1:0]       trk_dist,
	output unit_res_t               res
);

	logic               found_q;
	logic [DIST_W-1:0]  best_key_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [TRACK_W-1:0] best_trk_q;
	logic [DIST_W-1:0]  key;
	logic               in_range;
	logic               take;

	always_comb begin
		if (opa > head) begin
			trk_dist = {1'b0, opa} - {1'b0, head};
		end else begin
			trk_dist = {1'b0, head} - {1'b0, opa};
		end
		if (ctl.use_dist) begin
			key = trk_dist;
		end else if (ctl.want_max) begin
			key = {1'b0, ~opa};
		end else begin
			key = {1'b0, opa};
		end
		in_range = (opa >= ctl.lo) && (opa <= ctl.hi);
		take = ctl.vld && !ctl.skip && in_range && (!found_q || key < best_key_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_idx_q <= ctl.idx;
			best_trk_q <= opa;
		end
	end

	assign res = '{found: found_q, idx: best_idx_q, track: best_trk_q};

endmodule

`default_nettype wire

/* hw/rtl/disk_request_scheduler.sv */
// ----------------------------------------------------------------------------
// Disk request scheduler
// Stores request tracks and emits the service order for SSTF, SCAN or C-LOOK.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     req_t (opcode, track)
// out       output     out_valid / out_ready   rsp_t (service_track, total_seek, last)
// cfg       input      cfg_we                  cfg_idx, cfg_wdata
//
// A load is taken whenever the block is idle. Each track that a run serves takes
// one pass of the shared compare unit over the n stored requests in the RAM.
// Reset is asynchronous, clears the store count and restores the configuration defaults.
// A stalled output holds the sequencer until the pending request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_request_scheduler import drs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire req_t                 in_req,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rsp_t                      out_rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_PICK  = 3'd3;
	localparam logic [2:0] S_VISIT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [1:0] PH_DRAIN1 = 2'd0;
	localparam logic [1:0] PH_TURN   = 2'd1;
	localparam logic [1:0] PH_DRAIN2 = 2'd2;
	localparam logic [1:0] PH_END    = 2'd3;

	logic [2:0]              state_q;
	logic [1:0]              phase_q;
	logic [1:0]              alg_q;
	logic                    right_q;
	logic [CFG_W-1:0]        size_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [MAX_REQUESTS-1:0] served_q;
	logic [TRACK_W-1:0]      head_q;
	logic [TRACK_W-1:0]      head0_q;
	logic [TRACK_W-1:0]      vtrack_q;
	logic [TRACK_W-1:0]      pend_q;
	logic                    pend_v_q;
	logic [SEEK_W-1:0]       seek_q;
	logic                    out_valid_q;
	rsp_t                    out_q;

	logic [TRACK_W-1:0] rd_data;
	logic [TRACK_W-1:0] opa;
	logic [DIST_W-1:0]  trk_dist;
	unit_ctl_t          ctl;
	unit_res_t          res;
	logic               is_scan;
	logic               is_clook;
	logic               slot_free;
	logic               accept;
	logic               load_we;
	logic [CFG_W-1:0]   turn_end;
	logic [TRACK_W-1:0] turn_trk;

	assign is_scan   = (alg_q == ALG_SCAN);
	assign is_clook  = (alg_q == ALG_CLOOK);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load_we   = accept && (in_req.opcode == OP_LOAD) && (count_q < CNT_W'(MAX_REQUESTS));
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;
	assign opa       = (state_q == S_VISIT) ? vtrack_q : rd_data;

	drs_ram #(.WIDTH(TRACK_W), .DEPTH(MAX_REQUESTS)) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_req.track),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_comb begin
		ctl.clear    = (state_q == S_IDLE) || (state_q == S_PICK) || (state_q == S_VISIT);
		ctl.vld      = vld_s1;
		ctl.skip     = served_q[idx_s1];
		ctl.idx      = idx_s1;
		ctl.use_dist = !is_scan && !is_clook;
		if (is_scan && (phase_q == PH_DRAIN2)) begin
			ctl.want_max = right_q;
		end else begin
			ctl.want_max = !right_q;
		end
		ctl.lo = '0;
		ctl.hi = '1;
		if (!ctl.use_dist && (phase_q == PH_DRAIN1)) begin
			if (right_q) begin
				ctl.lo = head0_q;
			end else begin
				ctl.hi = head0_q;
			end
		end
	end

	drs_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.opa      (opa),
		.head     (head_q),
		.trk_dist (trk_dist),
		.res      (res)
	);

	always_comb begin
		if (size_q == '0) begin
			turn_end = '0;
		end else begin
			turn_end = size_q - CFG_W'(1);
		end
		if (turn_end[CFG_W-1]) begin
			turn_trk = '1;
		end else begin
			turn_trk = turn_end[TRACK_W-1:0];
		end
		if (turn_trk < head_q) begin
			turn_trk = head_q;
		end
		if (!right_q) begin
			turn_trk = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q   <= ALG_SSTF;
			right_q <= 1'b1;
			size_q  <= CFG_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ALGORITHM:   alg_q   <= cfg_wdata[1:0];
				REG_SWEEP_RIGHT: right_q <= cfg_wdata[0];
				REG_DISK_SIZE:   size_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_DRAIN1;
			count_q     <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			served_q    <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			idx_s1 <= idx_q;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_we) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (accept && (in_req.opcode == OP_RUN)) begin
						served_q <= '0;
						pend_v_q <= 1'b0;
						idx_q    <= '0;
						if (count_q == '0) begin
							phase_q <= PH_END;
							state_q <= S_VISIT;
						end else begin
							phase_q <= PH_DRAIN1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if ({1'b0, idx_q} == count_q - CNT_W'(1)) begin
						state_q <= S_WAIT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_WAIT: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					idx_q <= '0;
					if (res.found) begin
						served_q[res.idx] <= 1'b1;
						state_q <= S_VISIT;
					end else if (phase_q == PH_DRAIN1 && is_scan) begin
						phase_q <= PH_TURN;
						state_q <= S_VISIT;
					end else if (phase_q == PH_DRAIN1 && is_clook) begin
						phase_q <= PH_DRAIN2;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_VISIT: begin
					if (!pend_v_q || slot_free) begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						if (phase_q == PH_END) begin
							state_q <= S_FIN;
						end else begin
							if (phase_q == PH_TURN) begin
								phase_q <= PH_DRAIN2;
							end
							state_q <= S_SCAN;
						end
					end
				end
				S_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						pend_v_q    <= 1'b0;
						count_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && (in_req.opcode == OP_RUN)) begin
					head_q   <= in_req.track;
					head0_q  <= in_req.track;
					vtrack_q <= in_req.track;
					seek_q   <= '0;
				end
			end
			S_PICK: begin
				if (res.found) begin
					vtrack_q <= res.track;
				end else begin
					vtrack_q <= turn_trk;
				end
			end
			S_VISIT: begin
				if (!pend_v_q || slot_free) begin
					if (pend_v_q) begin
						out_q <= '{service_track: pend_q, total_seek: '0, last: 1'b0};
					end
					pend_q <= vtrack_q;
					seek_q <= seek_q + SEEK_W'(trk_dist);
					head_q <= vtrack_q;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					out_q <= '{service_track: pend_q, total_seek: seek_q, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* verif/disk_request_scheduler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Disk request scheduler testbench
// Loads request tracks and starts runs under every algorithm, direction and
// several disk sizes. A scoreboard works out each run's service order and
// seek total and checks every result request as it leaves the block.
// ----------------------------------------------------------------------------

module disk_request_scheduler_tb;
	import drs_pkg::*;

	class sched_scoreboard;
		logic [TRACK_W-1:0] tracks[$];
		logic [1:0]         alg;
		logic               right;
		logic [CFG_W-1:0]   dsize;
		rsp_t               pending[$];
		int                 errors;
		int                 runs;
		int                 results;

		function new();
			alg = ALG_SSTF;
			right = 1'b1;
			dsize = 17'd65536;
			errors = 0;
			runs = 0;
			results = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_ALGORITHM: alg = val[1:0];
				REG_SWEEP_RIGHT: right = val[0];
				REG_DISK_SIZE: dsize = val;
				default: ;
			endcase
		endfunction

		function void note_request(req_t r);
			bit served[$];
			int head, seek, pos, best, bd, d, tend, i;
			int order[$];
			rsp_t o;
			if (r.opcode == OP_LOAD) begin
				if (tracks.size() < MAX_REQUESTS) tracks.push_back(r.track);
				return;
			end
			runs++;
			head = int'(r.track);
			foreach (tracks[k]) served.push_back(0);
			if (tracks.size() == 0) begin
				order.push_back(head);
			end else if (alg == ALG_SCAN || alg == ALG_CLOOK) begin
				pos = head;
				for (int pass = 0; pass < 2; pass++) begin
					forever begin
						best = -1;
						foreach (tracks[k]) begin
							if (served[k]) continue;
							if (pass == 0 && right && tracks[k] < head) continue;
							if (pass == 0 && !right && tracks[k] > head) continue;
							if (best < 0) best = k;
							else if (right == (pass == 0 || alg == ALG_CLOOK)
									? tracks[k] < tracks[best] : tracks[k] > tracks[best])
								best = k;
						end
						if (best < 0) break;
						served[best] = 1;
						order.push_back(int'(tracks[best]));
						pos = int'(tracks[best]);
					end
					if (pass == 0 && alg == ALG_SCAN) begin
						if (right) begin
							tend = (dsize == 0) ? 0 : int'(dsize) - 1;
							if (tend > 65535) tend = 65535;
							if (tend < pos) tend = pos;
						end else tend = 0;
						order.push_back(tend);
					end
				end
			end else begin
				pos = head;
				forever begin
					best = -1;
					bd = 0;
					foreach (tracks[k]) begin
						if (served[k]) continue;
						d = tracks[k] > pos ? tracks[k] - pos : pos - tracks[k];
						if (best < 0 || d < bd) begin
							best = k;
							bd = d;
						end
					end
					if (best < 0) break;
					served[best] = 1;
					order.push_back(int'(tracks[best]));
					pos = int'(tracks[best]);
				end
			end
			pos = head;
			seek = 0;
			for (i = 0; i < order.size(); i++) begin
				seek += order[i] > pos ? order[i] - pos : pos - order[i];
				pos = order[i];
				o.service_track = TRACK_W'(order[i]);
				o.last = (i == order.size() - 1);
				o.total_seek = o.last ? seek[SEEK_W-1:0] : '0;
				pending.push_back(o);
			end
			tracks.delete();
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			results++;
			if (pending.size() == 0) begin
				$error("unexpected result: track %0d", a.service_track);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.service_track !== e.service_track) begin
				$error("service_track: expected %0d, actual %0d", e.service_track,
					a.service_track);
				errors++;
			end
			if (a.total_seek !== e.total_seek) begin
				$error("total_seek: expected %0d, actual %0d", e.total_seek, a.total_seek);
				errors++;
			end
			if (a.last !== e.last) begin
				$error("last: expected %0d, actual %0d", e.last, a.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_rsp;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	sched_scoreboard sb = new();
	int cycle_count = 0;
	int hold_off = 0;
	bit wide_tracks = 0;

	disk_request_scheduler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_result(out_rsp);
	end

	// The receiver waits a random number of cycles before each result.
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_ready <= 1'b0;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end
			w = $urandom_range(0, 5);
			if (cycle_count % 4000 < 1500) w = 0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_request(logic op, logic [TRACK_W-1:0] trk);
		int w;
		req_t r;
		w = $urandom_range(0, 5);
		if (cycle_count % 5000 < 2000) w = 0;
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		r.opcode = op;
		r.track = trk;
		in_valid <= 1'b1;
		in_req <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [TRACK_W-1:0] rand_track();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return TRACK_W'($urandom_range(0, 15));
			default: return wide_tracks ? TRACK_W'($urandom()) : TRACK_W'($urandom_range(0, 300));
		endcase
	endfunction

	task automatic random_batch(int loads);
		for (int i = 0; i < loads; i++) begin
			if ($urandom_range(0, 30) == 0) send_request(OP_RUN, rand_track());
			send_request(OP_LOAD, rand_track());
		end
		send_request(OP_RUN, rand_track());
	endtask

	initial begin
		int sent;
		int sizes[6] = '{1, 2, 200, 4096, 65536, 131071};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty run, extremes, equal tracks, ties and a full store.
		send_request(OP_RUN, 16'd500);
		send_request(OP_LOAD, 16'd10);
		send_request(OP_LOAD, 16'd20);
		send_request(OP_LOAD, 16'd15);
		send_request(OP_LOAD, 16'd25);
		send_request(OP_RUN, 16'd15);
		send_request(OP_LOAD, 16'hFFFF);
		send_request(OP_LOAD, 16'd0);
		send_request(OP_RUN, 16'h8000);
		drain_results();
		for (int a = 0; a < 4; a++) begin
			for (int d = 0; d < 2; d++) begin
				write_reg(REG_ALGORITHM, CFG_W'(a));
				write_reg(REG_SWEEP_RIGHT, CFG_W'(d));
				write_reg(REG_DISK_SIZE, (a == 1 && d == 1) ? 17'd100 : 17'd65536);
				send_request(OP_LOAD, 16'd40);
				send_request(OP_LOAD, 16'd150);
				send_request(OP_LOAD, 16'd50);
				send_request(OP_RUN, 16'd50);
				drain_results();
			end
		end
		write_reg(REG_ALGORITHM, CFG_W'(ALG_SSTF));
		for (int i = 0; i < 34; i++) send_request(OP_LOAD, TRACK_W'(i * 7));
		send_request(OP_RUN, 16'd100);
		drain_results();

		// The receiver stalls for a long stretch while loads and runs keep coming.
		hold_off = 400;
		for (int i = 0; i < 10; i++) send_request(OP_LOAD, TRACK_W'($urandom_range(0, 200)));
		send_request(OP_RUN, 16'd100);
		send_request(OP_LOAD, 16'd3);
		send_request(OP_RUN, 16'd9);
		drain_results();

		sent = 0;
		while (sent < 370) begin
			write_reg(REG_ALGORITHM, CFG_W'($urandom_range(0, 3)));
			write_reg(REG_SWEEP_RIGHT, CFG_W'($urandom_range(0, 1)));
			write_reg(REG_DISK_SIZE, CFG_W'(sizes[$urandom_range(0, 5)]));
			wide_tracks = $urandom_range(0, 1);
			for (int b = 0; b < 4; b++) begin
				int n;
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 10);
				random_batch(n);
				sent += n + 1;
			end
			drain_results();
		end
		drain_results();
		$display("Covered %0d runs and %0d result requests across all algorithms,",
			sb.runs, sb.results);
		$display("both sweep directions, disk size extremes and a full store.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/drs_pkg.sv
hw/rtl/drs_ram.sv
hw/rtl/drs_unit.sv
hw/rtl/disk_request_scheduler.sv
verif/disk_request_scheduler_tb.sv
